// ----- sv/pst_pkg.sv -----
// Shared types, codes and helper functions for the Pascal-subset tokenizer.
package pst_pkg;

    localparam int MAX_IDENT     = 32;
    localparam int POSITION_BITS = 16;
    localparam int KW_SLOTS      = 8;
    localparam int LEN_BITS      = $clog2(MAX_IDENT + 1);
    localparam int START_BITS    = 16;
    localparam int TLEN_BITS     = 6;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [LEN_BITS-1:0]      wlen_t;
    typedef logic [KW_SLOTS*8-1:0]    wchars_t;

    // token kinds
    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_PROGRAM = 5'd1;
    localparam logic [4:0] KIND_TRUE    = 5'd7;
    localparam logic [4:0] KIND_IDENT   = 5'd9;
    localparam logic [4:0] KIND_NUMBER  = 5'd10;
    localparam logic [4:0] KIND_ASSIGN  = 5'd11;
    localparam logic [4:0] KIND_COLON   = 5'd12;
    localparam logic [4:0] KIND_SEMI    = 5'd13;
    localparam logic [4:0] KIND_COMMA   = 5'd14;
    localparam logic [4:0] KIND_DOT     = 5'd15;
    localparam logic [4:0] KIND_PLUS    = 5'd16;
    localparam logic [4:0] KIND_MINUS   = 5'd17;
    localparam logic [4:0] KIND_STAR    = 5'd18;
    localparam logic [4:0] KIND_SLASH   = 5'd19;
    localparam logic [4:0] KIND_UNKNOWN = 5'd20;

    // byte classes
    localparam logic [2:0] CLS_ZERO   = 3'd0;
    localparam logic [2:0] CLS_SPACE  = 3'd1;
    localparam logic [2:0] CLS_LETTER = 3'd2;
    localparam logic [2:0] CLS_DIGIT  = 3'd3;
    localparam logic [2:0] CLS_COLON  = 3'd4;
    localparam logic [2:0] CLS_EQ     = 3'd5;
    localparam logic [2:0] CLS_PUNCT  = 3'd6;
    localparam logic [2:0] CLS_OTHER  = 3'd7;

    // keywords, first letter in the top byte, zero padded
    localparam wchars_t KW_TEXT [8] = '{
        {"program", 8'h00}, {"var", 40'h0}, {"begin", 24'h0}, {"end", 40'h0},
        {"integer", 8'h00}, {"boolean", 8'h00}, {"true", 32'h0}, {"false", 24'h0}
    };
    localparam int KW_LEN [8] = '{7, 3, 5, 3, 7, 7, 4, 5};

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] lc;     // lower-cased byte
        logic [4:0] pkind;  // kind for punctuation bytes
        logic       last;
        pos_t       pos;
    } cls_item_t;

    typedef struct packed {
        logic [4:0]            kind;
        logic [31:0]           value;
        logic [START_BITS-1:0] start;
        logic [TLEN_BITS-1:0]  tlen;
        logic                  ovf;
        logic                  lor;
    } tok_t;

    function automatic tok_t tok_simple(logic [4:0] kind, pos_t start);
        tok_t t;
        t       = '0;
        t.kind  = kind;
        t.start = START_BITS'(start);
        return t;
    endfunction

    function automatic tok_t tok_num(logic [31:0] acc, logic sat, pos_t start);
        tok_t t;
        t       = tok_simple(KIND_NUMBER, start);
        t.value = acc;
        t.ovf   = sat;
        return t;
    endfunction

    function automatic tok_t tok_word(wchars_t chars, wlen_t len, logic sat, pos_t start);
        tok_t t;
        logic found;
        t     = tok_simple(KIND_IDENT, start);
        found = 1'b0;
        if (!sat && len <= LEN_BITS'(KW_SLOTS))
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (!found && chars == KW_TEXT[k] && len == LEN_BITS'(KW_LEN[k]))
                begin
                    found  = 1'b1;
                    t.kind = KIND_PROGRAM + 5'(k);
                end
            end
        end
        t.value = (t.kind == KIND_TRUE) ? 32'd1 : 32'd0;
        t.tlen  = TLEN_BITS'(len);
        t.ovf   = sat;
        return t;
    endfunction

endpackage

// ----- sv/pst_front.sv -----
// Front end: accepts source bytes, classifies them and tags them with their offset.
module pst_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        ch,
    input  logic              last,
    input  logic              push,
    output logic              full,
    output pst_pkg::cls_item_t item,
    output logic              item_push,
    input  logic              q_full
);
    import pst_pkg::*;

    pos_t pos_reg;
    pos_t pos_next;
    logic accept;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign item_push = accept;

    always_comb
    begin
        item       = '0;
        item.last  = last;
        item.pos   = pos_reg;
        item.lc    = ch;
        item.pkind = KIND_UNKNOWN;
        if (ch == 8'd0)
            item.cls = CLS_ZERO;
        else if (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13))
            item.cls = CLS_SPACE;
        else if (ch >= "A" && ch <= "Z")
        begin
            item.cls = CLS_LETTER;
            item.lc  = ch | 8'h20;
        end
        else if (ch >= "a" && ch <= "z")
            item.cls = CLS_LETTER;
        else if (ch >= "0" && ch <= "9")
            item.cls = CLS_DIGIT;
        else if (ch == ":")
            item.cls = CLS_COLON;
        else if (ch == "=")
            item.cls = CLS_EQ;
        else
        begin
            item.cls = CLS_PUNCT;
            case (ch)
                ";":     item.pkind = KIND_SEMI;
                ",":     item.pkind = KIND_COMMA;
                ".":     item.pkind = KIND_DOT;
                "+":     item.pkind = KIND_PLUS;
                "-":     item.pkind = KIND_MINUS;
                "*":     item.pkind = KIND_STAR;
                "/":     item.pkind = KIND_SLASH;
                default: item.cls   = CLS_OTHER;
            endcase
        end
    end

    // offset restarts after the end of each source
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (ch == 8'd0 || last)
                pos_next = '0;
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// ----- sv/pst_cq.sv -----
// Two-entry queue of classified bytes between front and back end.
module pst_cq (
    input  logic               clk,
    input  logic               rst_n,
    input  pst_pkg::cls_item_t wr_data,
    input  logic               wr,
    output logic               full,
    output pst_pkg::cls_item_t rd_data,
    output logic               valid,
    input  logic               rd
);
    import pst_pkg::*;

    cls_item_t  mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && valid;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/pst_back.sv -----
// Back end: scanner state and token sequencer, one token per cycle while the token queue has room.
module pst_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pst_pkg::cls_item_t item,
    input  logic               item_valid,
    output logic               item_pop,
    output pst_pkg::tok_t      tok,
    output logic               tok_push,
    input  logic               tok_full
);
    import pst_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_COLON  = 2'd3;

    logic [1:0]  mode_reg, mode_next;
    wchars_t     wchars_reg, wchars_next;
    wlen_t       wlen_reg, wlen_next;
    logic [31:0] acc_reg, acc_next;
    logic        sat_reg, sat_next;
    pos_t        tstart_reg, tstart_next;
    logic [1:0]  idx_reg, idx_next;

    tok_t        tk [3];
    logic [1:0]  n;
    logic        handled;
    logic [35:0] prod;
    logic        commit;
    logic        at_end;

    // times ten plus digit
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, item.lc[3:0]};

    always_comb
    begin
        tk[0]       = '0;
        tk[1]       = '0;
        tk[2]       = '0;
        n           = 2'd0;
        handled     = 1'b0;
        at_end      = 1'b0;
        mode_next   = mode_reg;
        wchars_next = wchars_reg;
        wlen_next   = wlen_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        tstart_next = tstart_reg;

        if (item.cls == CLS_ZERO)
        begin
            case (mode_reg)
                MODE_WORD:
                begin
                    tk[n] = tok_word(wchars_reg, wlen_reg, sat_reg, tstart_reg);
                    n     = n + 2'd1;
                end
                MODE_NUMBER:
                begin
                    tk[n] = tok_num(acc_reg, sat_reg, tstart_reg);
                    n     = n + 2'd1;
                end
                MODE_COLON:
                begin
                    tk[n] = tok_simple(KIND_COLON, tstart_reg);
                    n     = n + 2'd1;
                end
                default: ;
            endcase
            tk[n]  = tok_simple(KIND_EOF, item.pos);
            n      = n + 2'd1;
            at_end = 1'b1;
        end
        else
        begin
            // close or extend the pending token
            case (mode_reg)
                MODE_WORD:
                begin
                    if (item.cls == CLS_LETTER || item.cls == CLS_DIGIT)
                    begin
                        handled = 1'b1;
                        if (wlen_reg < LEN_BITS'(MAX_IDENT))
                        begin
                            if (wlen_reg < LEN_BITS'(KW_SLOTS))
                                wchars_next[(KW_SLOTS - 1 - int'(wlen_reg[2:0])) * 8 +: 8] =
                                    item.lc;
                            wlen_next = wlen_reg + 1'b1;
                        end
                        else
                            sat_next = 1'b1;
                    end
                    else
                    begin
                        tk[n]     = tok_word(wchars_reg, wlen_reg, sat_reg, tstart_reg);
                        n         = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (item.cls == CLS_DIGIT)
                    begin
                        handled = 1'b1;
                        if (prod[35:32] != 4'd0)
                        begin
                            acc_next = 32'hFFFF_FFFF;
                            sat_next = 1'b1;
                        end
                        else
                            acc_next = prod[31:0];
                    end
                    else
                    begin
                        tk[n]     = tok_num(acc_reg, sat_reg, tstart_reg);
                        n         = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COLON:
                begin
                    mode_next = MODE_IDLE;
                    if (item.cls == CLS_EQ)
                    begin
                        handled = 1'b1;
                        tk[n]   = tok_simple(KIND_ASSIGN, tstart_reg);
                    end
                    else
                        tk[n]   = tok_simple(KIND_COLON, tstart_reg);
                    n = n + 2'd1;
                end
                default: ;
            endcase

            // fresh byte
            if (!handled && item.cls != CLS_SPACE)
            begin
                tstart_next = item.pos;
                sat_next    = 1'b0;
                case (item.cls)
                    CLS_LETTER:
                    begin
                        mode_next   = MODE_WORD;
                        wchars_next = {item.lc, {(KW_SLOTS - 1) * 8{1'b0}}};
                        wlen_next   = LEN_BITS'(1);
                    end
                    CLS_DIGIT:
                    begin
                        mode_next = MODE_NUMBER;
                        acc_next  = {28'd0, item.lc[3:0]};
                    end
                    CLS_COLON:
                        mode_next = MODE_COLON;
                    CLS_PUNCT:
                    begin
                        tk[n] = tok_simple(item.pkind, item.pos);
                        n     = n + 2'd1;
                    end
                    default:
                    begin
                        tk[n] = tok_simple(KIND_UNKNOWN, item.pos);
                        n     = n + 2'd1;
                    end
                endcase
            end

            // last byte: flush what this byte left pending, then eof past it
            if (item.last)
            begin
                case (mode_next)
                    MODE_WORD:
                    begin
                        tk[n] = tok_word(wchars_next, wlen_next, sat_next, tstart_next);
                        n     = n + 2'd1;
                    end
                    MODE_NUMBER:
                    begin
                        tk[n] = tok_num(acc_next, sat_next, tstart_next);
                        n     = n + 2'd1;
                    end
                    MODE_COLON:
                    begin
                        tk[n] = tok_simple(KIND_COLON, tstart_next);
                        n     = n + 2'd1;
                    end
                    default: ;
                endcase
                tk[n]  = tok_simple(KIND_EOF, item.pos + 1'b1);
                n      = n + 2'd1;
                at_end = 1'b1;
            end
        end

        if (at_end)
        begin
            mode_next   = MODE_IDLE;
            wchars_next = '0;
            wlen_next   = '0;
            acc_next    = '0;
            sat_next    = 1'b0;
            tstart_next = '0;
        end
    end

    // sequencer: one token a cycle unless tok_full, state committed with the last one (or at once if none)
    always_comb
    begin
        tok     = tk[idx_reg];
        tok.lor = (idx_reg == n - 2'd1);
    end

    assign tok_push = item_valid && (n != 2'd0) && !tok_full;
    assign commit   = item_valid &&
                      ((n == 2'd0) || (!tok_full && idx_reg == n - 2'd1));
    assign item_pop = commit;

    always_comb
    begin
        if (commit)
            idx_next = 2'd0;
        else if (tok_push)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            wchars_reg <= '0;
            wlen_reg   <= '0;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            tstart_reg <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (commit)
            begin
                mode_reg   <= mode_next;
                wchars_reg <= wchars_next;
                wlen_reg   <= wlen_next;
                acc_reg    <= acc_next;
                sat_reg    <= sat_next;
                tstart_reg <= tstart_next;
            end
        end
    end

`ifndef SYNTH
    a_lor_pops: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push && tok.lor |-> item_pop)
        else $error("last token pushed without retiring its byte");

    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> item_valid && idx_reg < n)
        else $error("token sequence lost its byte");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop && (item.cls == CLS_ZERO || item.last) |=>
            mode_reg == MODE_IDLE && wlen_reg == '0 && acc_reg == '0)
        else $error("state not cleared after end of source");

    a_end_eof: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push && tok.lor && (item.cls == CLS_ZERO || item.last) |->
            tok.kind == KIND_EOF)
        else $error("end of source without trailing eof");
`endif

endmodule

// ----- sv/pst_tq.sv -----
// Two-entry output queue of finished tokens.
module pst_tq (
    input  logic          clk,
    input  logic          rst_n,
    input  pst_pkg::tok_t wr_data,
    input  logic          wr,
    output logic          full,
    output pst_pkg::tok_t rd_data,
    output logic          empty,
    input  logic          rd
);
    import pst_pkg::*;

    tok_t       mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/pascal_subset_tokenizer_top.sv -----
// Top level of the Pascal-subset tokenizer: front end, byte queue, back end, token queue.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  bytes    | in        | push / full        | ch[7:0], last
//  tokens   | out       | pop / empty        | kind[4:0], value[31:0], start_pos[15:0],
//           |           |                    | text_len[5:0], overflow, last_of_run
//
//  A byte request is taken at any edge where full is low; the back end retires one byte a cycle
//  while the token queue has room, and a byte that makes tokens (at most three) is retired
//  with its last token. The token sequencer in the back end writes one token a cycle into the
//  output queue while that queue is not full. The first token of a byte passes through the byte
//  queue and then the token queue before it reaches the output ports and can be popped.
//  Reset (rst_n low, asynchronous) empties both queues and puts the scanner in its idle state.
//  A stalled output fills the token queue, then the byte queue, and only then raises full.
module pascal_subset_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        last,
    input  logic        push,
    output logic        full,
    output logic [4:0]  kind,
    output logic [31:0] value,
    output logic [15:0] start_pos,
    output logic [5:0]  text_len,
    output logic        overflow,
    output logic        last_of_run,
    output logic        empty,
    input  logic        pop
);
    import pst_pkg::*;

    cls_item_t front_item;
    logic      front_push;
    logic      cq_full;
    cls_item_t back_item;
    logic      back_valid;
    logic      back_pop;
    tok_t      back_tok;
    logic      tok_push;
    logic      tq_full;
    tok_t      out_tok;

    // classify each byte and tag it with its source offset
    pst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .last      (last),
        .push      (push),
        .full      (full),
        .item      (front_item),
        .item_push (front_push),
        .q_full    (cq_full)
    );

    // decouples the classifier from the token sequencer
    pst_cq u_cq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (front_item),
        .wr      (front_push),
        .full    (cq_full),
        .rd_data (back_item),
        .valid   (back_valid),
        .rd      (back_pop)
    );

    // scanner state, keyword match, number accumulate, token emission
    pst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_pop   (back_pop),
        .tok        (back_tok),
        .tok_push   (tok_push),
        .tok_full   (tq_full)
    );

    // holds finished tokens so the back end keeps going while the consumer stalls
    pst_tq u_tq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (back_tok),
        .wr      (tok_push),
        .full    (tq_full),
        .rd_data (out_tok),
        .empty   (empty),
        .rd      (pop)
    );

    assign kind        = out_tok.kind;
    assign value       = out_tok.value;
    assign start_pos   = out_tok.start;
    assign text_len    = out_tok.tlen;
    assign overflow    = out_tok.ovf;
    assign last_of_run = out_tok.lor;

endmodule
